[src/swsr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the single-wire send-then-receive master.
// No dependencies; imported by swsr_seq and the top level.
package swsr_pkg;

  localparam int BYTE_W       = 8;
  localparam int PERIOD_W     = 10;
  localparam int DATA_W       = 16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd10;

  // One time tick as seen by the sequencer.
  typedef struct packed {
    logic              send_request;
    logic [BYTE_W-1:0] send_byte;
    logic              line_in;
  } item_t;

  // Line and receive status after one tick.
  typedef struct packed {
    logic              line_out;
    logic              line_enable;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
    logic              busy_res;
  } result_t;

endpackage

[src/swsr_seq.sv]
`timescale 1ns / 1ps
// Transaction sequencer: request latch, bit timer, shift registers and phase.
// Depends on swsr_pkg. Advances one tick whenever step is high.
module swsr_seq #(
  parameter int DATA_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  swsr_pkg::item_t                    item,
  input  logic [swsr_pkg::PERIOD_W-1:0]      bit_period,
  output swsr_pkg::result_t                  res
);
  import swsr_pkg::*;

  localparam int CNT_W = $clog2(DATA_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_BITS);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEND,
    PH_RECV,
    PH_COOL
  } phase_t;

  phase_t                phase, phase_next;
  logic [CNT_W-1:0]      bit_count, bit_count_next;
  logic [PERIOD_W-1:0]   period_timer, period_timer_next;
  logic [DATA_BITS-1:0]  tx_shift, tx_shift_next;
  logic [DATA_BITS-1:0]  rx_shift, rx_shift_next;
  logic [DATA_BITS-1:0]  rx_hold, rx_hold_next;
  logic                  pending_flag, pending_flag_next;
  logic [DATA_BITS-1:0]  pending_byte, pending_byte_next;
  logic                  drive_level, drive_level_next;
  logic                  drive_on, drive_on_next;
  logic                  valid_next;
  logic [PERIOD_W-1:0]   eff_period;

  assign eff_period = (bit_period == '0) ? PERIOD_W'(1) : bit_period;

  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    period_timer_next = period_timer;
    tx_shift_next     = tx_shift;
    rx_shift_next     = rx_shift;
    rx_hold_next      = rx_hold;
    pending_flag_next = pending_flag;
    pending_byte_next = pending_byte;
    drive_level_next  = drive_level;
    drive_on_next     = drive_on;
    valid_next        = 1'b0;

    // latch a request, even mid-transaction; a newer one overwrites
    if (item.send_request) begin
      pending_flag_next = 1'b1;
      pending_byte_next = item.send_byte[DATA_BITS-1:0];
    end

    if (phase == PH_IDLE) begin
      if (pending_flag_next) begin
        pending_flag_next = 1'b0;
        tx_shift_next     = pending_byte_next;
        drive_level_next  = 1'b1;
        drive_on_next     = 1'b1;
        bit_count_next    = '0;
        period_timer_next = eff_period;
        phase_next        = PH_SEND;
      end
    end else if (period_timer != '0) begin
      period_timer_next = period_timer - PERIOD_W'(1);
    end else begin
      unique case (phase)
        PH_SEND: begin
          if (bit_count < CNT_LAST) begin
            // MSB first: drive the top bit, then shift it out
            drive_level_next  = tx_shift[DATA_BITS-1];
            tx_shift_next     = tx_shift << 1;
            bit_count_next    = bit_count + CNT_W'(1);
            period_timer_next = eff_period - PERIOD_W'(1);
          end else begin
            drive_level_next  = 1'b0;
            drive_on_next     = 1'b0;
            bit_count_next    = '0;
            rx_shift_next     = '0;
            period_timer_next = eff_period - PERIOD_W'(1);
            phase_next        = PH_RECV;
          end
        end
        PH_RECV: begin
          if (bit_count < CNT_LAST) begin
            rx_shift_next     = DATA_BITS'({rx_shift, item.line_in});
            bit_count_next    = bit_count + CNT_W'(1);
            period_timer_next = eff_period - PERIOD_W'(1);
          end else begin
            rx_hold_next      = rx_shift;
            valid_next        = 1'b1;
            period_timer_next = eff_period;
            phase_next        = PH_COOL;
          end
        end
        PH_COOL: begin
          drive_level_next = 1'b0;
          drive_on_next    = 1'b1;
          bit_count_next   = '0;
          phase_next       = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= '0;
      period_timer <= '0;
      tx_shift     <= '0;
      rx_shift     <= '0;
      rx_hold      <= '0;
      pending_flag <= 1'b0;
      pending_byte <= '0;
      drive_level  <= 1'b0;
      drive_on     <= 1'b1;
    end else if (step) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      period_timer <= period_timer_next;
      tx_shift     <= tx_shift_next;
      rx_shift     <= rx_shift_next;
      rx_hold      <= rx_hold_next;
      pending_flag <= pending_flag_next;
      pending_byte <= pending_byte_next;
      drive_level  <= drive_level_next;
      drive_on     <= drive_on_next;
    end
  end

  always_comb begin
    res.line_out    = drive_level_next;
    res.line_enable = drive_on_next;
    res.rx_valid    = valid_next;
    res.rx_byte     = BYTE_W'(rx_hold_next);
    res.busy_res    = (phase_next != PH_IDLE);
  end

`ifndef SYNTHESIS
  // the line is only released while receiving or cooling down
  a_release_phase: assert property (@(posedge clk) disable iff (rst)
    !drive_on |-> (phase == PH_RECV || phase == PH_COOL))
    else $error("line released outside receive/cooldown");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= CNT_LAST)
    else $error("bit counter overran data width");

  a_valid_single: assert property (@(posedge clk) disable iff (rst)
    (step && valid_next) |=> !valid_next)
    else $error("receive report lasted more than one tick");

  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    valid_next |-> (phase == PH_RECV && phase_next == PH_COOL))
    else $error("receive report outside end of receive");
`endif

endmodule

[src/single_wire_send_then_receive_core.sv]
`timescale 1ns / 1ps
// Top level of the single-wire send-then-receive master: stream ports,
// input and result registers, bit period register. Depends on swsr_pkg, swsr_seq.
//
// Usage:
//   Each request on the s_ channel is one time tick. tuser carries send_request,
//   tdata carries send_byte and the sampled wire level line_in. A send request
//   is latched and starts a transaction once the master is idle: a high start
//   pulse of one period plus one tick, DATA_BITS data bits MSB first, then the
//   wire is released, DATA_BITS bits are sampled one period apart, the byte is
//   reported (tuser high for one result) and a cooldown of one period plus one
//   tick follows.
//   Every accepted tick yields exactly one result on the m_ channel with the
//   line drive level, drive enable, received byte and busy flag.
//   Each result passes through the input register, then the result register. Throughput:
//   one tick per cycle while m_tready does not stall the result register, set by the
//   single pass through the sequencer's next-state logic.
//   A stall on m_tready holds the result register; the input register keeps at
//   most one more tick, and s_tready is low while both are full and m_tready low.
//   bit_period is written on the cfg_ channel (always ready), 0 acts as 1.
//   Reset: idle, line driven low, bit period 10, no request pending.
module single_wire_send_then_receive_core #(
  parameter int DATA_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [swsr_pkg::DATA_W-1:0]   s_tdata,   // [7:0] send_byte, [8] line_in
  input  logic                          s_tuser,   // [0] send_request
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [swsr_pkg::DATA_W-1:0]   m_tdata,   // [0] line_out, [1] line_enable,
                                                   // [9:2] rx_byte, [10] busy_res
  output logic                          m_tuser,   // [0] rx_valid
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swsr_pkg::PERIOD_W-1:0] cfg_data
);
  import swsr_pkg::*;

  logic                in_valid;
  item_t               in_item;
  logic                out_valid;
  result_t             out_res;
  result_t             step_res;
  logic                advance;
  logic [PERIOD_W-1:0] bit_period;

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= PERIOD_RESET;
    end else if (cfg_valid) begin
      bit_period <= cfg_data;
    end
  end

  // input register: hold the tick until the sequencer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.send_request <= s_tuser;
      in_item.send_byte    <= s_tdata[BYTE_W-1:0];
      in_item.line_in      <= s_tdata[BYTE_W];
    end
  end

  swsr_seq #(
    .DATA_BITS (DATA_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .item       (in_item),
    .bit_period (bit_period),
    .res        (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.rx_valid;
  assign m_tdata  = {5'b0, out_res.busy_res, out_res.rx_byte,
                     out_res.line_enable, out_res.line_out};

endmodule

[tb/sv/swsr_link_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the single-wire send-then-receive core: tracks the wire sequencer
// tick by tick and compares every result request. Depends on swsr_pkg.
module swsr_link_checker #(
  parameter int DATA_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [swsr_pkg::DATA_W-1:0]   s_tdata,   // [7:0] send_byte, [8] line_in
  input  logic                          s_tuser,   // [0] send_request
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [swsr_pkg::DATA_W-1:0]   m_tdata,   // [0] line_out, [1] line_enable,
                                                   // [9:2] rx_byte, [10] busy_res
  input  logic                          m_tuser,   // [0] rx_valid
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [swsr_pkg::PERIOD_W-1:0] cfg_data,
  output int                            errors,
  output int                            outstanding,
  output int                            ticks,
  output int                            reports,
  output logic                          quiet
);
  import swsr_pkg::*;

  typedef enum logic [1:0] {LINK_IDLE, LINK_SEND, LINK_RECV, LINK_COOL} link_phase_t;

  logic [PERIOD_W-1:0] period_q;
  link_phase_t         phase_q;
  logic [3:0]          bit_cnt_q;
  logic [PERIOD_W-1:0] timer_q;
  logic [BYTE_W-1:0]   tx_q;
  logic [BYTE_W-1:0]   rx_q;
  logic [BYTE_W-1:0]   rx_hold_q;
  logic [BYTE_W-1:0]   pend_byte_q;
  logic                pend_q;
  logic                level_q;
  logic                drive_q;
  result_t             wire_due[$];

  // Nothing in flight and no request latched: safe to drain and reconfigure.
  assign quiet = (phase_q == LINK_IDLE) && !pend_q;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic reset_link();
    period_q    = PERIOD_RESET;
    phase_q     = LINK_IDLE;
    bit_cnt_q   = '0;
    timer_q     = '0;
    tx_q        = '0;
    rx_q        = '0;
    rx_hold_q   = '0;
    pend_byte_q = '0;
    pend_q      = 1'b0;
    level_q     = 1'b0;
    drive_q     = 1'b1;
  endtask

  task automatic advance_tick(input logic req, input logic [BYTE_W-1:0] payload,
                              input logic line, output result_t r);
    int   p;
    logic valid;
    p     = (period_q == '0) ? 1 : int'(period_q);
    valid = 1'b0;
    // a later request overwrites the latched byte
    if (req) begin
      pend_q      = 1'b1;
      pend_byte_q = payload;
    end
    if (phase_q == LINK_IDLE) begin
      if (pend_q) begin
        pend_q    = 1'b0;
        tx_q      = pend_byte_q;
        level_q   = 1'b1;
        drive_q   = 1'b1;
        bit_cnt_q = '0;
        timer_q   = PERIOD_W'(p);
        phase_q   = LINK_SEND;
      end
    end else if (timer_q != '0) begin
      timer_q = timer_q - 1'b1;
    end else if (phase_q == LINK_SEND) begin
      if (bit_cnt_q < DATA_BITS) begin
        level_q   = tx_q[DATA_BITS-1-bit_cnt_q];
        bit_cnt_q = bit_cnt_q + 1'b1;
        timer_q   = PERIOD_W'(p - 1);
      end else begin
        level_q   = 1'b0;
        drive_q   = 1'b0;
        bit_cnt_q = '0;
        rx_q      = '0;
        timer_q   = PERIOD_W'(p - 1);
        phase_q   = LINK_RECV;
      end
    end else if (phase_q == LINK_RECV) begin
      if (bit_cnt_q < DATA_BITS) begin
        rx_q      = {rx_q[BYTE_W-2:0], line};
        bit_cnt_q = bit_cnt_q + 1'b1;
        timer_q   = PERIOD_W'(p - 1);
      end else begin
        rx_hold_q = rx_q;
        valid     = 1'b1;
        timer_q   = PERIOD_W'(p);
        phase_q   = LINK_COOL;
      end
    end else begin
      level_q   = 1'b0;
      drive_q   = 1'b1;
      bit_cnt_q = '0;
      phase_q   = LINK_IDLE;
    end
    r.line_out    = level_q;
    r.line_enable = drive_q;
    r.rx_valid    = valid;
    r.rx_byte     = rx_hold_q;
    r.busy_res    = (phase_q != LINK_IDLE);
  endtask

  always @(posedge clk) begin : watch
    result_t due;
    result_t fresh;
    if (rst) begin
      reset_link();
      wire_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) period_q = cfg_data;
      if (m_tvalid && m_tready) begin
        if (wire_due.size() == 0) begin
          report_mismatch("result with nothing outstanding", 1, 0);
        end else begin
          due = wire_due.pop_front();
          if (m_tdata[0] !== due.line_out)
            report_mismatch("line_out", m_tdata[0], due.line_out);
          if (m_tdata[1] !== due.line_enable)
            report_mismatch("line_enable", m_tdata[1], due.line_enable);
          if (m_tdata[9:2] !== due.rx_byte)
            report_mismatch("rx_byte", m_tdata[9:2], due.rx_byte);
          if (m_tdata[10] !== due.busy_res)
            report_mismatch("busy_res", m_tdata[10], due.busy_res);
          if (m_tuser !== due.rx_valid)
            report_mismatch("rx_valid", m_tuser, due.rx_valid);
          if (m_tdata[DATA_W-1:11] !== '0)
            report_mismatch("tdata padding", m_tdata[DATA_W-1:11], 0);
          if (due.rx_valid) reports++;
        end
      end
      if (s_tvalid && s_tready) begin
        advance_tick(s_tuser, s_tdata[BYTE_W-1:0], s_tdata[BYTE_W], fresh);
        wire_due.push_back(fresh);
        ticks++;
      end
    end
    outstanding = wire_due.size();
  end

endmodule

[tb/sv/tb_single_wire_send_then_receive_core.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for single_wire_send_then_receive_core: drives time ticks
// and bit period writes; checking lives in swsr_link_checker. Depends on swsr_pkg.
module tb_single_wire_send_then_receive_core;
  import swsr_pkg::*;

  localparam int DATA_BITS    = 8;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_TICKS = 400;
  localparam int PHASE_TICKS  = 80;
  localparam int LONG_HOLD    = 80;
  localparam int WIDE_TICKS   = 40;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [DATA_W-1:0]   s_tdata   = '0;
  logic                s_tuser   = 1'b0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [DATA_W-1:0]   m_tdata;
  logic                m_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [PERIOD_W-1:0] cfg_data  = '0;

  int   errors;
  int   outstanding;
  int   ticks;
  int   reports;
  logic quiet;

  int   sender_gap_pct = 0;
  int   rx_stall_pct   = 0;
  int   hold_left      = 0;
  logic hold_trigger   = 1'b0;
  logic hold_seen      = 1'b0;
  int   cycle_count    = 0;

  single_wire_send_then_receive_core #(.DATA_BITS(DATA_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  swsr_link_checker #(.DATA_BITS(DATA_BITS)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding),
    .ticks       (ticks),
    .reports     (reports),
    .quiet       (quiet)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_single_wire_send_then_receive_core: FAIL");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off when triggered.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offer one tick and return at the falling edge after it is taken; tvalid stays high.
  task automatic send_tick(input logic req, input logic [BYTE_W-1:0] payload,
                           input logic line);
    while ($urandom_range(99) < sender_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {{(DATA_W-BYTE_W-1){1'b0}}, line, payload};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Run idle ticks until the transaction ends, then hold the input until all results drain.
  task automatic settle();
    while (!quiet) send_tick(1'b0, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int random_ticks;
    int phase_no;
    int req_pct;
    int toggle;
    random_ticks = 0;
    phase_no     = 0;
    toggle       = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset period: request from idle starts on the same tick, wire held high.
    send_tick(1'b1, 8'hA5, 1'b1);
    while (!quiet) send_tick(1'b0, 8'h00, 1'b1);

    // Zero period acts as one; requests while busy latch and overwrite.
    write_period('0);
    send_tick(1'b1, 8'h00, 1'b0);
    repeat (5) send_tick(1'b0, 8'h00, 1'b0);
    send_tick(1'b1, 8'hFF, 1'b0);
    send_tick(1'b1, 8'h3C, 1'b1);
    // latched request starts the tick after cooldown ends
    while (!quiet) begin
      send_tick(1'b0, 8'h00, toggle[0]);
      toggle++;
    end

    while (random_ticks < RANDOM_TICKS) begin
      case (phase_no % 4)
        0: begin sender_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin sender_gap_pct = 50; rx_stall_pct = 0;  end
        2: begin sender_gap_pct = 0;  rx_stall_pct = 50; end
        default: begin sender_gap_pct = 24; rx_stall_pct = 24; end
      endcase
      write_period((phase_no % 5 == 4) ? PERIOD_W'(9) : PERIOD_W'($urandom_range(4)));
      // fill the pipeline against a stalled output
      if (phase_no == 2) hold_trigger <= ~hold_trigger;
      req_pct = 5 + $urandom_range(20);
      repeat (PHASE_TICKS) begin
        send_tick($urandom_range(99) < req_pct, BYTE_W'($urandom_range(255)),
                  1'($urandom_range(1)));
        random_ticks++;
      end
      phase_no++;
    end

    // Widest bit period: run into the long start pulse at full rate, then drain.
    sender_gap_pct = 0;
    rx_stall_pct   = 0;
    write_period(PERIOD_MAX);
    send_tick(1'b1, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
    repeat (WIDE_TICKS) send_tick(1'b0, 8'h00, 1'b1);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d ticks with %0d bytes received over %0d random phases,",
             ticks, reports, phase_no);
    $display("bit periods 0 to %0d, four idling mixes and a long output hold-off.",
             PERIOD_MAX);
    if (errors == 0) begin
      $display("tb_single_wire_send_then_receive_core: PASS");
    end else begin
      $display("tb_single_wire_send_then_receive_core: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
src/swsr_pkg.sv
src/swsr_seq.sv
src/single_wire_send_then_receive_core.sv
tb/sv/swsr_link_checker.sv
tb/sv/tb_single_wire_send_then_receive_core.sv
